// ----- sv/lacc_pkg.sv -----
// Lane accumulator package: transaction structs, command and readout codes.
// No dependencies; imported by every module of the lane accumulator.
`timescale 1ns / 1ps
`default_nettype none
package lacc_pkg;

	localparam int LANES_DEF = 8;
	localparam int ACC_W     = 48;
	localparam int PROD_W    = 32;
	localparam int VAL_W     = 16;
	localparam int LANE_W    = 3;

	typedef enum logic [1:0] {
		CMD_ZEXT  = 2'd0,
		CMD_SEXT  = 2'd1,
		CMD_SHIFT = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RD_MID_CLAMP = 2'd0,
		RD_LOW       = 2'd1,
		RD_LOW_CLAMP = 2'd2,
		RD_MID       = 2'd3
	} read_mode_t;

	localparam logic [VAL_W-1:0] SAT_POS      = 16'h7fff;
	localparam logic [VAL_W-1:0] SAT_NEG      = 16'h8000;
	localparam logic [VAL_W-1:0] SAT_LOW_MAX  = 16'hffff;
	localparam logic [VAL_W-1:0] SAT_LOW_MIN  = 16'h0000;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [LANE_W-1:0] lane;
		logic [PROD_W-1:0] product;
		logic              accumulate;
		logic [1:0]        read_mode;
	} item_t;

	typedef struct packed {
		logic [LANE_W-1:0] out_lane;
		logic [VAL_W-1:0]  read_value;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/lacc_update.sv -----
// Lane accumulator update path: product extension and 48-bit add or load.
// Depends on lacc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lacc_update
	import lacc_pkg::*;
(
	input  wire logic [1:0]        cmd,
	input  wire logic [PROD_W-1:0] product,
	input  wire logic              accumulate,
	input  wire logic [ACC_W-1:0]  acc,
	output logic      [ACC_W-1:0]  acc_next
);

	logic [ACC_W-1:0] ext;

	always_comb begin
		case (cmd)
			CMD_ZEXT:  ext = {16'h0000, product};
			CMD_SEXT:  ext = {{16{product[PROD_W-1]}}, product};
			CMD_SHIFT: ext = {product, 16'h0000};
			default:   ext = '0;
		endcase
	end

	assign acc_next = accumulate ? (acc + ext) : ext;

endmodule
`default_nettype wire

// ----- sv/lacc_readout.sv -----
// Lane accumulator readout: slice selection with signed and low clamping.
// Depends on lacc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lacc_readout
	import lacc_pkg::*;
(
	input  wire logic [ACC_W-1:0] acc,
	input  wire logic [1:0]       read_mode,
	output logic      [VAL_W-1:0] value
);

	logic [VAL_W-1:0] lo;
	logic [VAL_W-1:0] mid;
	logic             neg;
	logic             over;
	logic             under;

	assign lo    = acc[15:0];
	assign mid   = acc[31:16];
	assign neg   = acc[47];
	assign over  = !neg && (|acc[46:31]);
	assign under = neg && !(&acc[46:31]);

	always_comb begin
		case (read_mode)
			RD_MID_CLAMP: value = over ? SAT_POS : (under ? SAT_NEG : mid);
			RD_LOW:       value = lo;
			RD_LOW_CLAMP: value = over ? SAT_LOW_MAX : (under ? SAT_LOW_MIN : lo);
			RD_MID:       value = mid;
			default:      value = mid;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/lane_accumulator_48bit_clamp_top.sv -----
// Lane accumulator top: input register, lane accumulator store, result register.
// Depends on lacc_pkg, lacc_update and lacc_readout.
// A read transaction passes through the input register and then the result register before done is raised.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: all lane accumulators clear to zero and no result is pending.
// The receiver cannot stall: done is high for a single cycle per result.
`timescale 1ns / 1ps
`default_nettype none
module lane_accumulator_48bit_clamp_top
	import lacc_pkg::*;
#(
	parameter int LANES = LANES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire item_t   item,
	output logic         done,
	output result_t      result
);

	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam logic [4:0] LANES_V = 5'(LANES);

	logic             vld_s1;
	item_t            item_s1;
	logic [ACC_W-1:0] acc_q [LANES];
	logic             done_q;
	result_t          result_q;

	logic             lane_ok;
	logic [IDX_W-1:0] idx;
	logic [ACC_W-1:0] acc_cur;
	logic [ACC_W-1:0] acc_next;
	logic [VAL_W-1:0] rd_value;

	assign busy    = 1'b0;
	assign lane_ok = ({2'b00, item_s1.lane} < LANES_V);
	assign idx     = IDX_W'(item_s1.lane);
	assign acc_cur = lane_ok ? acc_q[idx] : '0;

	lacc_update u_update (
		.cmd        (item_s1.cmd),
		.product    (item_s1.product),
		.accumulate (item_s1.accumulate),
		.acc        (acc_cur),
		.acc_next   (acc_next)
	);

	lacc_readout u_readout (
		.acc       (acc_cur),
		.read_mode (item_s1.read_mode),
		.value     (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= '0;
			end
		end else if (vld_s1 && item_s1.cmd != CMD_READ && lane_ok) begin
			acc_q[idx] <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1 && item_s1.cmd == CMD_READ;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && item_s1.cmd == CMD_READ) begin
			result_q.out_lane   <= item_s1.lane;
			result_q.read_value <= lane_ok ? rd_value : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire
